// File: design/mst_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the miss status table.
// No dependencies; used by mst_cam, the top module and the testbench.
package mst_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PIGGY  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_FILL   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NO_MATCH  = 2'd2,
        ST_LIST_FULL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    typedef struct packed {
        logic alloc;
        logic free;
    } t_cam_cmd;

    localparam int unsigned SIZE_W  = 7;
    localparam int unsigned TAG_W   = 32;
    localparam int unsigned RID_W   = 32;
    localparam int unsigned SHIFT_W = 4;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;

endpackage

// File: design/mst_op_ram.sv
`timescale 1ns / 1ps
// Waiting-op store: one write port, one read port, registered read data.
// No package dependencies.
module mst_op_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 88
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/mst_cam.sv
`timescale 1ns / 1ps
// Entry tags, valid bits and age matrix; finds the oldest matching entry.
// Depends on mst_pkg.
module mst_cam #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 48,
    parameter int IDX_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mst_pkg::t_cam_cmd     i_cmd,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [ADDR_BITS-1:0]  i_block,
    input  logic [ADDR_BITS-1:0]  i_addr,
    input  logic [mst_pkg::SHIFT_W-1:0] i_shift,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_match_idx,
    output logic [ENTRIES-1:0]    o_valid_vec
);
    import mst_pkg::*;

    logic [ENTRIES-1:0]   r_valid;
    logic [ADDR_BITS-1:0] r_block [ENTRIES];
    // row i, bit j: entry j is older than entry i
    logic [ENTRIES-1:0]   r_older [ENTRIES];
    logic [ADDR_BITS-1:0] mask;
    logic [ENTRIES-1:0]   match;
    logic [ENTRIES-1:0]   sel;

    assign mask = ~((ADDR_BITS'(1) << i_shift) - ADDR_BITS'(1));

    always_comb begin
        o_match_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (((r_block[i] ^ i_addr) & mask) == '0);
        end
        for (int i = 0; i < ENTRIES; i++) begin
            sel[i] = match[i] && ((match & r_older[i]) == '0);
            if (sel[i]) begin
                o_match_idx = o_match_idx | IDX_W'(i);
            end
        end
    end

    assign o_found     = |match;
    assign o_valid_vec = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_older[i] <= '0;
            end
        end else begin
            if (i_cmd.alloc) begin
                // new entry is younger than everything
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == i_idx) begin
                        r_older[i] <= r_valid;
                    end else begin
                        r_older[i][i_idx] <= 1'b0;
                    end
                end
                r_valid[i_idx] <= 1'b1;
            end
            if (i_cmd.free) begin
                r_valid[i_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_block[i_idx] <= i_block;
        end
    end

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(sel)) else $error("more than one oldest match");
    a_found_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> $onehot(sel)) else $error("match without selected entry");
    a_alloc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.alloc && !i_cmd.free) |=> r_valid[$past(i_idx)])
        else $error("allocated entry not valid");
endmodule

// File: design/miss_status_table_with_forwarding_top.sv
`timescale 1ns / 1ps
// Miss status table with store forwarding: control FSM, free stack, op counts.
// Depends on mst_pkg, mst_cam and mst_op_ram.
// Flow: insert and piggyback give their result from the lookup state; a query with waiting
//   ops reads them through the registered RAM read and answers after the last; a fill gives
//   its releases one per cycle. One item at a time; busy is high until the last result.
// Throughput is set by the single read port of the op RAM, one waiting op per cycle.
// Reset (i_rst_n low at a clock edge) clears control state at once; no clearing pass.
// Results are strobed on o_valid for one cycle; the receiver cannot stall.
module miss_status_table_with_forwarding_top #(
    parameter int TABLE_ENTRIES = 16,
    parameter int OPS_PER_ENTRY = 8,
    parameter int ADDR_BITS     = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_op,
    input  logic                          i_is_store,
    input  logic [ADDR_BITS-1:0]          i_addr,
    input  logic [mst_pkg::SIZE_W-1:0]    i_size,
    input  logic [mst_pkg::TAG_W-1:0]     i_op_tag,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mst_pkg::SHIFT_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic                          o_hit,
    output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] o_entry_index,
    output logic [mst_pkg::RID_W-1:0]     o_request_id,
    output logic [mst_pkg::TAG_W-1:0]     o_released_tag,
    output logic                          o_released_is_store,
    output logic                          o_last
);
    import mst_pkg::*;

    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(OPS_PER_ENTRY + 1);
    localparam int FC_W      = $clog2(TABLE_ENTRIES + 1);
    localparam int RAM_DEPTH = TABLE_ENTRIES * OPS_PER_ENTRY;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int RAM_DW    = 1 + SIZE_W + TAG_W + ADDR_BITS;

    t_state               r_state;
    logic [SHIFT_W-1:0]   r_shift;
    // captured item
    t_op                  r_op;
    logic                 r_kind;
    logic [ADDR_BITS-1:0] r_addr;
    logic [SIZE_W-1:0]    r_size;
    logic [TAG_W-1:0]     r_tag;
    // table bookkeeping
    logic [RID_W-1:0]     r_rid;
    logic [FC_W-1:0]      r_fc;
    logic [IDX_W-1:0]     r_stack [TABLE_ENTRIES];
    logic [CNT_W-1:0]     r_wcnt  [TABLE_ENTRIES];
    // scan of one entry's op list
    logic [IDX_W-1:0]     r_e;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_ri;
    logic                 r_dv;
    logic                 r_dlast;
    logic                 r_hit;
    // result register
    logic                 r_ov;
    t_status              r_status;
    logic                 r_ohit;
    logic [IDX_W-1:0]     r_oidx;
    logic [RID_W-1:0]     r_orid;
    logic [TAG_W-1:0]     r_otag;
    logic                 r_okind;
    logic                 r_olast;

    logic                 accept;
    logic [IDX_W-1:0]     free_e;
    logic                 found;
    logic [IDX_W-1:0]     m_idx;
    logic [CNT_W-1:0]     m_cnt;
    logic [TABLE_ENTRIES-1:0] valid_vec;
    t_cam_cmd             cam_cmd;
    logic [IDX_W-1:0]     cam_idx;
    logic                 ram_we;
    logic [IDX_W-1:0]     wr_e;
    logic [CNT_W-1:0]     wr_slot;
    logic [RAM_AW-1:0]    ram_waddr;
    logic                 ram_re;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [RAM_DW-1:0]    ram_rdata;
    logic                 d_kind;
    logic [SIZE_W-1:0]    d_size;
    logic [TAG_W-1:0]     d_tag;
    logic [ADDR_BITS-1:0] d_addr;
    logic                 d_hit;
    logic                 fill_done;
    logic                 fill_empty;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;

    // top of the LIFO free stack
    assign free_e = r_stack[IDX_W'(r_fc - FC_W'(1))];
    assign m_cnt  = r_wcnt[m_idx];

    mst_cam #(
        .ENTRIES   (TABLE_ENTRIES),
        .ADDR_BITS (ADDR_BITS),
        .IDX_W     (IDX_W)
    ) u_cam (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cam_cmd),
        .i_idx       (cam_idx),
        .i_block     (r_addr),
        .i_addr      (r_addr),
        .i_shift     (r_shift),
        .o_found     (found),
        .o_match_idx (m_idx),
        .o_valid_vec (valid_vec)
    );

    // Free the entry either right away (empty list) or after the last release.
    assign fill_empty = (r_state == S_LOOK) && (r_op == OP_FILL) && found && (m_cnt == '0);
    assign fill_done  = (r_state == S_SCAN) && (r_op == OP_FILL) && r_dv && r_dlast;

    always_comb begin
        cam_cmd.alloc = (r_state == S_LOOK) && (r_op == OP_INSERT) && (r_fc != '0);
        cam_cmd.free  = fill_empty || fill_done;
        if (r_state == S_LOOK) begin
            cam_idx = (r_op == OP_INSERT) ? free_e : m_idx;
        end else begin
            cam_idx = r_e;
        end
    end

    // Appends happen only in the lookup cycle; reads only during a later scan,
    // so the RAM never sees a read and a write of the same slot together.
    always_comb begin
        ram_we  = 1'b0;
        wr_e    = m_idx;
        wr_slot = m_cnt;
        if (r_state == S_LOOK) begin
            if (r_op == OP_INSERT && r_fc != '0) begin
                ram_we  = 1'b1;
                wr_e    = free_e;
                wr_slot = '0;
            end else if (r_op == OP_PIGGY && found && m_cnt != CNT_W'(OPS_PER_ENTRY)) begin
                ram_we = 1'b1;
            end
        end
    end

    assign ram_waddr = RAM_AW'(wr_e) * RAM_AW'(OPS_PER_ENTRY) + RAM_AW'(wr_slot);
    assign ram_re    = (r_state == S_SCAN) && (r_ri != r_cnt);
    assign ram_raddr = RAM_AW'(r_e) * RAM_AW'(OPS_PER_ENTRY) + RAM_AW'(r_ri);

    mst_op_ram #(
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW),
        .DW    (RAM_DW)
    ) u_ops (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_kind, r_size, r_tag, r_addr}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign {d_kind, d_size, d_tag, d_addr} = ram_rdata;

    // A waiting store covers the access when it starts at or below it and ends at or above it.
    assign d_hit = d_kind && (d_addr <= r_addr) &&
        (({1'b0, r_addr} + (ADDR_BITS + 1)'(r_size)) <=
         ({1'b0, d_addr} + (ADDR_BITS + 1)'(d_size)));

    // Capture the item payload on transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_op);
            r_kind <= i_is_store;
            r_addr <= i_addr;
            r_size <= i_size;
            r_tag  <= i_op_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_shift <= SHIFT_RESET;
            r_fc    <= FC_W'(TABLE_ENTRIES);
            r_rid   <= '0;
            r_ov    <= 1'b0;
            r_dv    <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_stack[i] <= IDX_W'(i);
                r_wcnt[i]  <= '0;
            end
        end else begin
            r_ov <= 1'b0;
            r_dv <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_shift <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // default: one result with last set, done, other fields zero
                    r_ov     <= 1'b1;
                    r_olast  <= 1'b1;
                    r_status <= ST_DONE;
                    r_ohit   <= 1'b0;
                    r_oidx   <= '0;
                    r_orid   <= '0;
                    r_otag   <= '0;
                    r_okind  <= 1'b0;
                    r_state  <= S_IDLE;
                    case (r_op)
                        OP_INSERT: begin
                            if (r_fc == '0) begin
                                r_status <= ST_NO_FREE;
                            end else begin
                                r_fc           <= r_fc - FC_W'(1);
                                r_wcnt[free_e] <= CNT_W'(1);
                                r_rid          <= r_rid + RID_W'(1);
                                r_orid         <= r_rid + RID_W'(1);
                                r_oidx         <= free_e;
                            end
                        end
                        OP_PIGGY: begin
                            if (!found) begin
                                r_status <= ST_NO_MATCH;
                            end else begin
                                r_ohit <= 1'b1;
                                r_oidx <= m_idx;
                                if (m_cnt == CNT_W'(OPS_PER_ENTRY)) begin
                                    r_status <= ST_LIST_FULL;
                                end else begin
                                    r_wcnt[m_idx] <= m_cnt + CNT_W'(1);
                                end
                            end
                        end
                        OP_QUERY, OP_FILL: begin
                            if (!found) begin
                                r_status <= ST_NO_MATCH;
                            end else if (m_cnt == '0) begin
                                r_oidx <= m_idx;
                                if (r_op == OP_FILL) begin
                                    r_stack[IDX_W'(r_fc)] <= m_idx;
                                    r_fc                  <= r_fc + FC_W'(1);
                                end
                            end else begin
                                // hold the result, walk the op list
                                r_ov    <= 1'b0;
                                r_state <= S_SCAN;
                                r_e     <= m_idx;
                                r_cnt   <= m_cnt;
                                r_ri    <= '0;
                                r_hit   <= 1'b0;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_SCAN: begin
                    if (r_ri != r_cnt) begin
                        r_ri <= r_ri + CNT_W'(1);
                    end
                    r_dv    <= (r_ri != r_cnt);
                    r_dlast <= (r_ri == r_cnt - CNT_W'(1));
                    if (r_dv) begin
                        if (r_op == OP_FILL) begin
                            r_ov     <= 1'b1;
                            r_status <= ST_DONE;
                            r_ohit   <= 1'b0;
                            r_oidx   <= r_e;
                            r_orid   <= '0;
                            r_otag   <= d_tag;
                            r_okind  <= d_kind;
                            r_olast  <= r_dlast;
                            if (r_dlast) begin
                                r_wcnt[r_e]           <= '0;
                                r_stack[IDX_W'(r_fc)] <= r_e;
                                r_fc                  <= r_fc + FC_W'(1);
                                r_state               <= S_IDLE;
                            end
                        end else begin
                            r_hit <= r_hit || d_hit;
                            if (r_dlast) begin
                                r_ov     <= 1'b1;
                                r_status <= ST_DONE;
                                r_ohit   <= r_hit || d_hit;
                                r_oidx   <= r_e;
                                r_orid   <= '0;
                                r_otag   <= '0;
                                r_okind  <= 1'b0;
                                r_olast  <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid             = r_ov;
    assign o_status            = r_status;
    assign o_hit               = r_ohit;
    assign o_entry_index       = r_oidx;
    assign o_request_id        = r_orid;
    assign o_released_tag      = r_otag;
    assign o_released_is_store = r_okind;
    assign o_last              = r_olast;

    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= FC_W'(TABLE_ENTRIES)) else $error("free count overflow");
    a_fc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(valid_vec) + int'(r_fc)) == TABLE_ENTRIES)
        else $error("free stack and valid bits disagree");
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) != S_IDLE) else $error("result without work");
endmodule

// File: verif/tb_miss_status_table_with_forwarding_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for miss_status_table_with_forwarding_top.
// Depends on mst_pkg and the block RTL; drives directed rows, then random traffic
// through the start/busy command port and checks every strobed result in order.
module tb_miss_status_table_with_forwarding_top;
    import mst_pkg::*;

    localparam int ENTRIES = 16;
    localparam int DEPTH   = 8;
    localparam int AW      = 48;

    // One result as it appears on the result ports.
    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [3:0]  idx;
        logic [31:0] rid;
        logic [31:0] tag;
        logic        kind;
        logic        last;
    } t_res;

    // One directed stimulus row; typed rows carry a hand-written expectation.
    typedef struct {
        t_op         op;
        logic        kind;
        logic [47:0] addr;
        logic [6:0]  size;
        logic [31:0] tag;
        bit          typed;
        t_res        res;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_op;
    logic              i_is_store;
    logic [AW-1:0]     i_addr;
    logic [6:0]        i_size;
    logic [31:0]       i_op_tag;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [3:0]        i_cfg_data;
    logic              o_valid;
    logic [1:0]        o_status;
    logic              o_hit;
    logic [3:0]        o_entry_index;
    logic [31:0]       o_request_id;
    logic [31:0]       o_released_tag;
    logic              o_released_is_store;
    logic              o_last;

    miss_status_table_with_forwarding_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_is_store(i_is_store), .i_addr(i_addr), .i_size(i_size),
        .i_op_tag(i_op_tag), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_status(o_status), .o_hit(o_hit),
        .o_entry_index(o_entry_index), .o_request_id(o_request_id),
        .o_released_tag(o_released_tag), .o_released_is_store(o_released_is_store),
        .o_last(o_last)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the table, updated at each accepted transfer.
    // ---------------------------------------------------------------
    logic [3:0]   shadow_shift;
    bit           ent_valid [ENTRIES];
    logic [47:0]  ent_block [ENTRIES];
    int           age_list  [ENTRIES];
    int           age_cnt;
    int           free_list [ENTRIES];
    int           free_cnt;
    logic [31:0]  wait_tag  [ENTRIES][DEPTH];
    logic         wait_kind [ENTRIES][DEPTH];
    logic [47:0]  wait_addr [ENTRIES][DEPTH];
    logic [6:0]   wait_size [ENTRIES][DEPTH];
    int           wait_cnt  [ENTRIES];
    logic [31:0]  rid_count;

    t_res         pending_res[$];
    bit           failed;

    // Directed expectation travels with the transfer it belongs to.
    bit           row_typed;
    t_res         row_res;

    int           idle_pct;
    logic [47:0]  addr_pool[6];

    function automatic t_res mk_res(t_status st, int hit, int idx, logic [31:0] rid,
                                    logic [31:0] tag, int kind, int last);
        t_res r;
        r.status = st; r.hit = hit[0]; r.idx = idx[3:0]; r.rid = rid;
        r.tag = tag; r.kind = kind[0]; r.last = last[0];
        return r;
    endfunction

    // Append one expected result at the tail.
    function automatic void queue_res(t_res r);
        pending_res.insert(pending_res.size(), r);
    endfunction

    function automatic void reset_shadow();
        shadow_shift = SHIFT_RESET;
        age_cnt = 0;
        free_cnt = ENTRIES;
        rid_count = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            ent_valid[i] = 0;
            free_list[i] = i;
            wait_cnt[i] = 0;
        end
    endfunction

    function automatic int oldest_match(logic [47:0] a);
        for (int i = 0; i < age_cnt; i++) begin
            if (ent_valid[age_list[i]] &&
                (ent_block[age_list[i]] >> shadow_shift) == (a >> shadow_shift))
                return age_list[i];
        end
        return -1;
    endfunction

    function automatic bit store_covers(logic [47:0] sa, logic [6:0] ss,
                                        logic [47:0] a, logic [6:0] sz);
        longint unsigned off;
        if (sa > a) return 0;
        off = a - sa;
        if (off > ss) return 0;
        return sz <= ss - off;
    endfunction

    function automatic void append_access(int e, logic kind, logic [47:0] a,
                                          logic [6:0] sz, logic [31:0] tag);
        wait_tag[e][wait_cnt[e]]  = tag;
        wait_kind[e][wait_cnt[e]] = kind;
        wait_addr[e][wait_cnt[e]] = a;
        wait_size[e][wait_cnt[e]] = sz;
        wait_cnt[e]++;
    endfunction

    // Work out the results of one accepted command and queue them.
    function automatic void predict_table_op(t_op op, logic kind, logic [47:0] a,
                                             logic [6:0] sz, logic [31:0] tag);
        int  e;
        bit  hit;
        if (op == OP_INSERT) begin
            if (free_cnt == 0) begin
                queue_res(mk_res(ST_NO_FREE, 0, 0, 0, 0, 0, 1));
                return;
            end
            free_cnt--;
            e = free_list[free_cnt];
            ent_valid[e] = 1;
            ent_block[e] = a;
            wait_cnt[e] = 0;
            append_access(e, kind, a, sz, tag);
            rid_count++;
            age_list[age_cnt++] = e;
            queue_res(mk_res(ST_DONE, 0, e, rid_count, 0, 0, 1));
            return;
        end
        e = oldest_match(a);
        if (e < 0) begin
            queue_res(mk_res(ST_NO_MATCH, 0, 0, 0, 0, 0, 1));
            return;
        end
        case (op)
            OP_PIGGY: begin
                if (wait_cnt[e] >= DEPTH) begin
                    queue_res(mk_res(ST_LIST_FULL, 1, e, 0, 0, 0, 1));
                end else begin
                    append_access(e, kind, a, sz, tag);
                    queue_res(mk_res(ST_DONE, 1, e, 0, 0, 0, 1));
                end
            end
            OP_QUERY: begin
                hit = 0;
                for (int i = 0; i < wait_cnt[e]; i++)
                    if (wait_kind[e][i] && store_covers(wait_addr[e][i], wait_size[e][i], a, sz))
                        hit = 1;
                queue_res(mk_res(ST_DONE, hit, e, 0, 0, 0, 1));
            end
            default: begin
                if (wait_cnt[e] == 0)
                    queue_res(mk_res(ST_DONE, 0, e, 0, 0, 0, 1));
                for (int i = 0; i < wait_cnt[e]; i++)
                    queue_res(mk_res(ST_DONE, 0, e, 0, wait_tag[e][i],
                                     wait_kind[e][i], i + 1 == wait_cnt[e]));
                wait_cnt[e] = 0;
                ent_valid[e] = 0;
                // Close the gap in the age list.
                for (int i = 0; i < age_cnt; i++) begin
                    if (age_list[i] == e) begin
                        for (int j = i; j + 1 < age_cnt; j++) age_list[j] = age_list[j + 1];
                        age_cnt--;
                        break;
                    end
                end
                free_list[free_cnt++] = e;
            end
        endcase
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1;
        end
    endtask

    // ---------------------------------------------------------------
    // Clock, and a hard stop in case the block hangs.
    // ---------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("miss_status_table_with_forwarding_top: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Monitor: check strobed results first, then predict the command
    // accepted at this edge, so a result and a new transfer on the same
    // edge stay in order.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_res.size() == 0) begin
                    $error("result strobed with nothing expected");
                    failed = 1;
                end else begin
                    want = pending_res[0];
                    pending_res.delete(0);
                    check_field("status", want.status, o_status);
                    check_field("hit", want.hit, o_hit);
                    check_field("entry_index", want.idx, o_entry_index);
                    check_field("request_id", want.rid, o_request_id);
                    check_field("released_tag", want.tag, o_released_tag);
                    check_field("released_is_store", want.kind, o_released_is_store);
                    check_field("last", want.last, o_last);
                end
            end
            if (i_cfg_valid && o_cfg_ready) shadow_shift = i_cfg_data;
            if (start && !busy) begin
                predict_table_op(t_op'(i_op), i_is_store, i_addr, i_size, i_op_tag);
                // Hand-typed rows replace the single predicted result.
                if (row_typed) pending_res[pending_res.size() - 1] = row_res;
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------

    // Present one command, with random idle cycles ahead of it, and hold
    // it until the transfer happens. Returns on the accepting edge.
    task automatic issue(t_op op, logic kind, logic [47:0] a, logic [6:0] sz,
                         logic [31:0] tag, bit typed, t_res res);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start      <= 1;
        i_op       <= op;
        i_is_store <= kind;
        i_addr     <= a;
        i_size     <= sz;
        i_op_tag   <= tag;
        row_typed  <= typed;
        row_res    <= res;
        do @(posedge i_clk); while (!(start && !busy));
    endtask

    // Drop start and wait until every queued result has come out, then
    // let the block finish any trailing work.
    task automatic drain();
        start <= 0;
        do @(posedge i_clk); while (pending_res.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_shift(logic [3:0] v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    function automatic logic [47:0] rand_addr48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] pick_addr();
        logic [47:0] a;
        a = addr_pool[$urandom_range(5)];
        // Mostly exact pool addresses; some nearby bytes, some far away.
        case ($urandom_range(9))
            0:       return rand_addr48();
            1, 2:    return a + 48'($urandom_range(63));
            default: return a;
        endcase
    endfunction

    task automatic random_item(bit inserts_only);
        t_op        op;
        int         w;
        logic [6:0] sz;
        w = $urandom_range(99);
        if (inserts_only)  op = OP_INSERT;
        else if (w < 30)   op = OP_INSERT;
        else if (w < 60)   op = OP_PIGGY;
        else if (w < 80)   op = OP_QUERY;
        else               op = OP_FILL;
        sz = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64, 1));
        issue(op, 1'($urandom_range(1)), pick_addr(), sz, $urandom, 0, '0);
    endtask

    task automatic random_phase(int n);
        foreach (addr_pool[i]) addr_pool[i] = rand_addr48();
        for (int i = 0; i < n; i++) random_item(0);
    endtask

    t_row rows[$];

    function automatic void add_row(t_op op, logic kind, logic [47:0] a, logic [6:0] sz,
                                    logic [31:0] tag, bit typed, t_res res);
        t_row r;
        r.op = op; r.kind = kind; r.addr = a; r.size = sz; r.tag = tag;
        r.typed = typed; r.res = res;
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        t_res none;
        none = '0;
        failed = 0;
        reset_shadow();
        idle_pct    = 0;
        i_rst_n     = 0;
        start       = 0;
        i_op        = OP_INSERT;
        i_is_store  = 0;
        i_addr      = '0;
        i_size      = '0;
        i_op_tag    = '0;
        i_cfg_valid = 0;
        i_cfg_data  = '0;
        row_typed   = 0;
        row_res     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed rows, at the reset block size of 64 bytes.
        // Empty table: every lookup misses.
        add_row(OP_FILL,  0, 48'h0, 7'd1, 32'h0, 1, mk_res(ST_NO_MATCH, 0, 0, 0, 0, 0, 1));
        add_row(OP_QUERY, 1, 48'h0, 7'd1, 32'h0, 1, mk_res(ST_NO_MATCH, 0, 0, 0, 0, 0, 1));
        add_row(OP_PIGGY, 0, 48'h0, 7'd1, 32'h0, 1, mk_res(ST_NO_MATCH, 0, 0, 0, 0, 0, 1));
        // First inserts take the top of the free stack: highest index first.
        add_row(OP_INSERT, 0, 48'h1000, 7'd1, 32'h0, 1, mk_res(ST_DONE, 0, 15, 1, 0, 0, 1));
        add_row(OP_INSERT, 1, 48'hFFFF_FFFF_FFC0, 7'd64, 32'hFFFF_FFFF, 1,
                mk_res(ST_DONE, 0, 14, 2, 0, 0, 1));
        add_row(OP_PIGGY, 1, 48'h1008, 7'd8, 32'hA5A5_0001, 1, mk_res(ST_DONE, 1, 15, 0, 0, 0, 1));
        // Store-to-load forwarding: exact cover, one byte past, store asking.
        add_row(OP_QUERY, 0, 48'h1008, 7'd8, 32'h0, 0, none);
        add_row(OP_QUERY, 0, 48'h1008, 7'd9, 32'h0, 0, none);
        add_row(OP_QUERY, 1, 48'hFFFF_FFFF_FFFF, 7'd1, 32'h0, 0, none);
        add_row(OP_QUERY, 1, 48'hFFFF_FFFF_FFC0, 7'd0, 32'h0, 0, none);
        // Same block again still allocates a new entry.
        add_row(OP_INSERT, 1, 48'h1004, 7'd127, 32'h5A5A_0002, 1,
                mk_res(ST_DONE, 0, 13, 3, 0, 0, 1));
        // Fill the op list of the oldest entry, then overflow it.
        for (int i = 0; i < 6; i++)
            add_row(OP_PIGGY, i[0], 48'h1010 + 48'(i), 7'd4, 32'h100 + i, 0, none);
        add_row(OP_PIGGY, 0, 48'h1020, 7'd4, 32'h200, 1, mk_res(ST_LIST_FULL, 1, 15, 0, 0, 0, 1));
        // Fill releases all eight waiting accesses, then the duplicate entry.
        add_row(OP_FILL, 0, 48'h1000, 7'd1, 32'h0, 0, none);
        add_row(OP_FILL, 0, 48'h1000, 7'd1, 32'h0, 0, none);
        add_row(OP_FILL, 0, 48'hFFFF_FFFF_FFC0, 7'd1, 32'h0, 0, none);
        // The most recently freed entry comes back first.
        add_row(OP_INSERT, 0, 48'h2000, 7'd0, 32'h7, 0, none);
        foreach (rows[i])
            issue(rows[i].op, rows[i].kind, rows[i].addr, rows[i].size, rows[i].tag,
                  rows[i].typed, rows[i].res);
        row_typed <= 0;

        // Phase 1: block size of 4096 bytes, sender idles 32 percent.
        write_shift(4'd12);
        idle_pct = 32;
        random_phase(8);
        // Overrun the table, then drain the pool blocks.
        for (int i = 0; i < 18; i++) random_item(1);
        foreach (addr_pool[i])
            repeat (3) issue(OP_FILL, 0, addr_pool[i], 7'd1, 32'h0, 0, none);
        random_phase(6);

        // Phase 2: exact-address matching, sender idles 61 percent.
        write_shift(4'd0);
        idle_pct = 61;
        random_phase(12);
        // Hold off until the block has gone quiet, then carry on.
        drain();
        random_phase(4);

        // Phase 3: largest block size, back-to-back commands.
        write_shift(4'd15);
        idle_pct = 0;
        random_phase(8);
        write_shift(SHIFT_RESET);
        random_phase(6);

        drain();
        if (!failed)
            $display("miss_status_table_with_forwarding_top: match");
        else
            $display("miss_status_table_with_forwarding_top: mismatch");
        $finish;
    end

endmodule
